// ===== rtl/core/grid_dfs_spanning_tree_macros.svh =====
// assertion macros shared by the grid walker rtl
`ifndef GRID_DFS_SPANNING_TREE_MACROS_SVH
`define GRID_DFS_SPANNING_TREE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GDST_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("gdst: same-cycle check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define GDST_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("gdst: next-cycle check failed");

`endif

// ===== rtl/core/gdst_pkg.sv =====
// shared types and constants of the grid depth-first walker
package gdst_pkg;

  localparam int DefMaxWidth   = 8;
  localparam int DefMaxHeight  = 8;
  localparam int DefStackDepth = 64;

  // at most this many edges per walk
  localparam int ResultLimit = 63;
  localparam int CountW      = 6;

  localparam int CfgW     = 4;
  localparam int ApbDataW = 32;
  localparam int ApbAddrW = 3;

  localparam logic [CfgW-1:0] ResetGridWidth  = 4'd8;
  localparam logic [CfgW-1:0] ResetGridHeight = 4'd8;

  // register index, taken from paddr[2]
  localparam logic RegGridWidth  = 1'b0;
  localparam logic RegGridHeight = 1'b1;

  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirLeft  = 2'd1;
  localparam logic [1:0] DirDown  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  localparam logic [1:0] StatusEdge    = 2'd0;
  localparam logic [1:0] StatusSingle  = 2'd1;
  localparam logic [1:0] StatusOutside = 2'd2;

  typedef struct packed {
    logic [2:0] start_x;
    logic [2:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic [1:0] move_dir;
    logic [1:0] status;
    logic       last;
  } out_item_t;

endpackage

// ===== rtl/core/gdst_ram.sv =====
// generic single-write, single-read ram with registered read data
module gdst_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gdst_step.sv =====
// neighbor probe unit: one direction per call, one add and one bound compare
module gdst_step #(
  parameter int  MAX_WIDTH  = 8,
  parameter int  MAX_HEIGHT = 8,
  localparam int CoordXW    = $clog2(MAX_WIDTH),
  localparam int CoordYW    = $clog2(MAX_HEIGHT),
  localparam int DimXW      = $clog2(MAX_WIDTH + 1),
  localparam int DimYW      = $clog2(MAX_HEIGHT + 1),
  localparam int Cells      = MAX_WIDTH * MAX_HEIGHT,
  localparam int IdxW       = $clog2(Cells)
) (
  input  logic [CoordXW-1:0] cur_x_i,
  input  logic [CoordYW-1:0] cur_y_i,
  input  logic [1:0]         dir_i,
  input  logic [DimXW-1:0]   dim_x_i,
  input  logic [DimYW-1:0]   dim_y_i,
  input  logic [Cells-1:0]   visited_i,
  output logic               hit_o,
  output logic [CoordXW-1:0] nx_o,
  output logic [CoordYW-1:0] ny_o,
  output logic [IdxW-1:0]    nidx_o
);
  import gdst_pkg::*;

  localparam int AxW = ((DimXW > DimYW) ? DimXW : DimYW) + 1;

  logic           vert;
  logic           inc;
  logic [AxW-1:0] axis;
  logic [AxW-1:0] lim;
  logic [AxW-1:0] sum;
  logic           in_grid;

  always_comb begin
    vert = (dir_i == DirUp) || (dir_i == DirDown);
    inc  = (dir_i == DirDown) || (dir_i == DirRight);
    axis = vert ? AxW'(cur_y_i) : AxW'(cur_x_i);
    lim  = vert ? AxW'(dim_y_i) : AxW'(dim_x_i);
    // minus one is an add of all ones; underflow shows in the top bit
    sum     = axis + (inc ? AxW'(1) : {AxW{1'b1}});
    in_grid = !sum[AxW-1] && (sum < lim);
    nx_o    = vert ? cur_x_i : sum[CoordXW-1:0];
    ny_o    = vert ? sum[CoordYW-1:0] : cur_y_i;
    nidx_o  = IdxW'(int'(ny_o) * MAX_WIDTH + int'(nx_o));
    hit_o   = in_grid && !visited_i[nidx_o];
  end

endmodule

// ===== rtl/core/gdst_ctrl.sv =====
// walk sequencer: visited map, coordinate stack, pending edge
module gdst_ctrl #(
  parameter int  MAX_WIDTH   = 8,
  parameter int  MAX_HEIGHT  = 8,
  parameter int  STACK_DEPTH = 64,
  localparam int CoordXW     = $clog2(MAX_WIDTH),
  localparam int CoordYW     = $clog2(MAX_HEIGHT),
  localparam int DimXW       = $clog2(MAX_WIDTH + 1),
  localparam int DimYW       = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  gdst_pkg::in_item_t  start_item_i,
  input  logic [DimXW-1:0]    dim_x_i,
  input  logic [DimYW-1:0]    dim_y_i,
  input  logic                out_free_i,
  output logic                busy_o,
  output logic                emit_valid_o,
  output gdst_pkg::out_item_t emit_item_o
);
  import gdst_pkg::*;

  localparam int Cells = MAX_WIDTH * MAX_HEIGHT;
  localparam int IdxW  = $clog2(Cells);
  localparam int TotW  = $clog2(Cells + 1);
  localparam int StW   = $clog2(STACK_DEPTH + 1);
  localparam int SaW   = $clog2(STACK_DEPTH);
  localparam int EntW  = CoordXW + CoordYW;

  typedef enum logic [1:0] {
    StIdle,
    StProbe,
    StPopWait,
    StFinal
  } state_e;

  state_e             state_q, state_d;
  logic [1:0]         dir_q, dir_d;
  logic [CoordXW-1:0] cur_x_q, cur_x_d;
  logic [CoordYW-1:0] cur_y_q, cur_y_d;
  logic [Cells-1:0]   visited_q, visited_d;
  logic [StW-1:0]     top_q, top_d;
  logic [TotW-1:0]    visit_q, visit_d;
  logic [TotW-1:0]    total_q, total_d;
  logic [CountW-1:0]  edges_q, edges_d;
  logic               pend_valid_q, pend_valid_d;
  out_item_t          pend_q, pend_d;

  logic               hit;
  logic [CoordXW-1:0] nx;
  logic [CoordYW-1:0] ny;
  logic [IdxW-1:0]    nidx;
  logic [IdxW-1:0]    sidx;
  logic               outside;
  logic [StW-1:0]     pop_top;

  logic               ram_we;
  logic [SaW-1:0]     ram_waddr;
  logic [EntW-1:0]    ram_wdata;
  logic [SaW-1:0]     ram_raddr;
  logic [EntW-1:0]    ram_rdata;

  gdst_step #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_step (
    .cur_x_i  (cur_x_q),
    .cur_y_i  (cur_y_q),
    .dir_i    (dir_q),
    .dim_x_i  (dim_x_i),
    .dim_y_i  (dim_y_i),
    .visited_i(visited_q),
    .hit_o    (hit),
    .nx_o     (nx),
    .ny_o     (ny),
    .nidx_o   (nidx)
  );

  gdst_ram #(
    .WIDTH(EntW),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    dir_d        = dir_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    visited_d    = visited_q;
    top_d        = top_q;
    visit_d      = visit_q;
    total_d      = total_q;
    edges_d      = edges_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    ram_we       = 1'b0;
    ram_waddr    = top_q[SaW-1:0];
    ram_wdata    = {ny, nx};
    ram_raddr    = '0;
    emit_valid_o = 1'b0;
    emit_item_o  = pend_q;
    pop_top      = (top_q != '0) ? top_q - StW'(1) : '0;
    outside      = (int'(start_item_i.start_x) >= int'(dim_x_i)) ||
                   (int'(start_item_i.start_y) >= int'(dim_y_i));
    sidx         = IdxW'(int'(CoordYW'(start_item_i.start_y)) * MAX_WIDTH +
                         int'(CoordXW'(start_item_i.start_x)));

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          visited_d    = '0;
          top_d        = '0;
          visit_d      = '0;
          edges_d      = '0;
          pend_valid_d = 1'b0;
          dir_d        = DirUp;
          total_d      = TotW'(dim_x_i) * TotW'(dim_y_i);
          if (outside) begin
            cur_x_d = '0;
            cur_y_d = '0;
            pend_d  = '{cell_x: 3'd0, cell_y: 3'd0, move_dir: DirUp,
                        status: StatusOutside, last: 1'b1};
            state_d = StFinal;
          end else begin
            cur_x_d         = CoordXW'(start_item_i.start_x);
            cur_y_d         = CoordYW'(start_item_i.start_y);
            visited_d[sidx] = 1'b1;
            ram_we          = 1'b1;
            ram_waddr       = '0;
            ram_wdata       = {CoordYW'(start_item_i.start_y),
                               CoordXW'(start_item_i.start_x)};
            top_d           = StW'(1);
            visit_d         = TotW'(1);
            if ((dim_x_i == DimXW'(1)) && (dim_y_i == DimYW'(1))) begin
              pend_d  = '{cell_x: start_item_i.start_x, cell_y: start_item_i.start_y,
                          move_dir: DirUp, status: StatusSingle, last: 1'b1};
              state_d = StFinal;
            end else begin
              state_d = StProbe;
            end
          end
        end
      end

      StProbe: begin
        if (!((visit_q < total_q) && (edges_q < CountW'(ResultLimit)))) begin
          state_d = StFinal;
        end else if (hit) begin
          // the previous edge leaves first; hold here while it cannot
          if (!pend_valid_q || out_free_i) begin
            emit_valid_o    = pend_valid_q;
            cur_x_d         = nx;
            cur_y_d         = ny;
            visited_d[nidx] = 1'b1;
            if (top_q < StW'(STACK_DEPTH)) begin
              ram_we = 1'b1;
              top_d  = top_q + StW'(1);
            end
            visit_d      = visit_q + TotW'(1);
            edges_d      = edges_q + CountW'(1);
            pend_d       = '{cell_x: 3'(nx), cell_y: 3'(ny), move_dir: dir_q,
                             status: StatusEdge, last: 1'b0};
            pend_valid_d = 1'b1;
            dir_d        = DirUp;
          end
        end else if (dir_q != DirRight) begin
          dir_d = dir_q + 2'd1;
        end else begin
          // dead end: pop and resume at the new top
          top_d = pop_top;
          dir_d = DirUp;
          if (pop_top == '0) begin
            state_d = StFinal;
          end else begin
            ram_raddr = SaW'(pop_top - StW'(1));
            state_d   = StPopWait;
          end
        end
      end

      StPopWait: begin
        cur_x_d = ram_rdata[CoordXW-1:0];
        cur_y_d = ram_rdata[CoordXW +: CoordYW];
        state_d = StProbe;
      end

      StFinal: begin
        emit_item_o.last = 1'b1;
        if (out_free_i) begin
          emit_valid_o = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      dir_q        <= DirUp;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      visited_q    <= '0;
      top_q        <= '0;
      visit_q      <= '0;
      total_q      <= '0;
      edges_q      <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      dir_q        <= dir_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      visited_q    <= visited_d;
      top_q        <= top_d;
      visit_q      <= visit_d;
      total_q      <= total_d;
      edges_q      <= edges_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

// ===== rtl/core/grid_dfs_spanning_tree.sv =====
// top level of the grid depth-first spanning tree walker
//
//   channel   direction  handshake                    payload
//   in        input      in_valid_i / in_stall_o      in_data_i  (start cell)
//   out       output     out_valid_o / out_stall_i    out_data_o (one tree edge)
//   cfg       input      psel/penable/pwrite/pready   grid_width @0, grid_height @4
//
// a fault or single-cell start goes straight to the final state; a walk probes up,
// left, down and right in turn through the single neighbor probe unit (one direction
// a cycle unless the walk is held), and a dead end pops the stack and waits on the
// registered read of the stack ram before probing resumes.
// reset sets an 8 by 8 grid and clears the walk state; in_stall_o rises after an
// accepted start beat and stays high until its final edge is loaded into the output
// register, and the walk holds while an earlier edge waits there under out_stall_i.
`include "grid_dfs_spanning_tree_macros.svh"

module grid_dfs_spanning_tree #(
  parameter int MAX_WIDTH   = gdst_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT  = gdst_pkg::DefMaxHeight,
  parameter int STACK_DEPTH = gdst_pkg::DefStackDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  gdst_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output gdst_pkg::out_item_t               out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gdst_pkg::ApbAddrW-1:0]     paddr,
  input  logic [gdst_pkg::ApbDataW-1:0]     pwdata,
  output logic [gdst_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);
  import gdst_pkg::*;

  localparam int DimXW = $clog2(MAX_WIDTH + 1);
  localparam int DimYW = $clog2(MAX_HEIGHT + 1);

  logic [CfgW-1:0]  cfg_w_q;
  logic [CfgW-1:0]  cfg_h_q;
  logic [CfgW-1:0]  rd_val;
  logic             cfg_we;
  logic [DimXW-1:0] dim_x;
  logic [DimYW-1:0] dim_y;

  logic             in_accept;
  logic             out_free;
  logic             busy;
  logic             emit_valid;
  out_item_t        emit_item;
  logic             out_valid_q;
  out_item_t        out_q;

  logic             out_fault;
  logic             out_outside;
  logic             outside_zero;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= ResetGridWidth;
      cfg_h_q <= ResetGridHeight;
    end else if (cfg_we) begin
      unique case (paddr[2])
        RegGridWidth:  cfg_w_q <= pwdata[CfgW-1:0];
        RegGridHeight: cfg_h_q <= pwdata[CfgW-1:0];
        default:       cfg_w_q <= cfg_w_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegGridWidth:  rd_val = cfg_w_q;
      RegGridHeight: rd_val = cfg_h_q;
      default:       rd_val = '0;
    endcase
    prdata = {{(ApbDataW - CfgW){1'b0}}, rd_val};
  end

  // zero acts as one, values past the maximum saturate
  always_comb begin
    if (cfg_w_q == '0) begin
      dim_x = DimXW'(1);
    end else if (int'(cfg_w_q) > MAX_WIDTH) begin
      dim_x = DimXW'(MAX_WIDTH);
    end else begin
      dim_x = DimXW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      dim_y = DimYW'(1);
    end else if (int'(cfg_h_q) > MAX_HEIGHT) begin
      dim_y = DimYW'(MAX_HEIGHT);
    end else begin
      dim_y = DimYW'(cfg_h_q);
    end
  end

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  gdst_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .start_item_i(in_data_i),
    .dim_x_i     (dim_x),
    .dim_y_i     (dim_y),
    .out_free_i  (out_free),
    .busy_o      (busy),
    .emit_valid_o(emit_valid),
    .emit_item_o (emit_item)
  );

  // output register parts the walk from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid) begin
      out_q <= emit_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_fault    = out_valid_o && (out_data_o.status != StatusEdge);
  assign out_outside  = out_valid_o && (out_data_o.status == StatusOutside);
  assign outside_zero = (out_data_o.cell_x == 3'd0) && (out_data_o.cell_y == 3'd0) &&
                        (out_data_o.move_dir == DirUp);

  `GDST_ASSERT_NEXT(a_busy_after_start, in_accept, in_stall_o)
  `GDST_ASSERT_IMPL(a_fault_is_last, out_fault, out_data_o.last)
  `GDST_ASSERT_IMPL(a_outside_zero, out_outside, outside_zero)

endmodule

// ===== bench/grid_dfs_spanning_tree_tb.sv =====
// self-checking testbench for the grid depth-first spanning tree walker
`timescale 1ns / 1ps

module grid_dfs_spanning_tree_tb;
  import gdst_pkg::*;

  localparam int MaxW       = DefMaxWidth;
  localparam int MaxH       = DefMaxHeight;
  localparam int StackDepth = DefStackDepth;
  localparam int CellW      = $clog2(MaxW * MaxH);
  localparam int IdleLimit  = 5000;
  localparam int NumProbeRows = 22;
  localparam int PhaseItems = 16;

  typedef struct {
    logic [CfgW-1:0] grid_w;
    logic [CfgW-1:0] grid_h;
    in_item_t        start;
    bit              typed;
    out_item_t       result;
  } probe_row_t;

  // typed rows: fault or single-cell answers, everything else goes through walk_tree
  probe_row_t probe_rows [NumProbeRows] = '{
    '{4'd8,  4'd8,  '{3'd0, 3'd0}, 1'b0, '0},
    '{4'd8,  4'd8,  '{3'd7, 3'd7}, 1'b0, '0},
    '{4'd8,  4'd8,  '{3'd3, 3'd4}, 1'b0, '0},
    '{4'd1,  4'd1,  '{3'd0, 3'd0}, 1'b1, '{3'd0, 3'd0, DirUp, StatusSingle, 1'b1}},
    '{4'd1,  4'd1,  '{3'd5, 3'd2}, 1'b1, '{3'd0, 3'd0, DirUp, StatusOutside, 1'b1}},
    '{4'd0,  4'd0,  '{3'd0, 3'd0}, 1'b1, '{3'd0, 3'd0, DirUp, StatusSingle, 1'b1}},
    '{4'd0,  4'd0,  '{3'd0, 3'd1}, 1'b1, '{3'd0, 3'd0, DirUp, StatusOutside, 1'b1}},
    '{4'd15, 4'd15, '{3'd7, 3'd7}, 1'b0, '0},
    '{4'd15, 4'd9,  '{3'd0, 3'd7}, 1'b0, '0},
    '{4'd4,  4'd3,  '{3'd4, 3'd0}, 1'b1, '{3'd0, 3'd0, DirUp, StatusOutside, 1'b1}},
    '{4'd4,  4'd3,  '{3'd0, 3'd3}, 1'b1, '{3'd0, 3'd0, DirUp, StatusOutside, 1'b1}},
    '{4'd4,  4'd3,  '{3'd3, 3'd2}, 1'b0, '0},
    '{4'd1,  4'd8,  '{3'd0, 3'd0}, 1'b0, '0},
    '{4'd1,  4'd8,  '{3'd0, 3'd7}, 1'b0, '0},
    '{4'd8,  4'd1,  '{3'd7, 3'd0}, 1'b0, '0},
    '{4'd8,  4'd1,  '{3'd0, 3'd0}, 1'b0, '0},
    '{4'd2,  4'd2,  '{3'd1, 3'd1}, 1'b0, '0},
    '{4'd0,  4'd5,  '{3'd0, 3'd2}, 1'b0, '0},
    '{4'd8,  4'd0,  '{3'd7, 3'd0}, 1'b0, '0},
    '{4'd8,  4'd8,  '{3'd2, 3'd5}, 1'b0, '0},
    '{4'd8,  4'd8,  '{3'd7, 3'd0}, 1'b0, '0},
    '{4'd1,  4'd1,  '{3'd7, 3'd7}, 1'b1, '{3'd0, 3'd0, DirUp, StatusOutside, 1'b1}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data = '0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  out_item_t           out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // predictor copy of the registers and the walk state
  logic [CfgW-1:0]  cfg_width = ResetGridWidth;
  logic [CfgW-1:0]  cfg_height = ResetGridHeight;
  bit               tree_visited [MaxW*MaxH];
  logic [CellW-1:0] tree_stack [StackDepth];
  int               tree_top;
  int               walk_x;
  int               walk_y;
  int               tree_count;

  out_item_t tree_edges_due[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  grid_dfs_spanning_tree u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_dim(input logic [CfgW-1:0] v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic bit bool_seen(input int x, input int y);
    return tree_visited[y * MaxW + x];
  endfunction

  function automatic void push_cell(input int x, input int y);
    // a full stack drops the push, the walk still moves
    if (tree_top < StackDepth) begin
      tree_stack[tree_top] = CellW'(y * MaxW + x);
      tree_top++;
    end
  endfunction

  function automatic void walk_tree(input in_item_t item, output out_item_t walk[$]);
    int         w;
    int         h;
    int         total;
    int         nx;
    int         ny;
    bit         found;
    logic [1:0] dir;
    out_item_t  step;
    walk.delete();
    w = eff_dim(cfg_width, MaxW);
    h = eff_dim(cfg_height, MaxH);
    total = w * h;
    foreach (tree_visited[i]) tree_visited[i] = 1'b0;
    tree_top = 0;
    tree_count = 0;
    if (item.start_x >= w || item.start_y >= h) begin
      walk_x = 0;
      walk_y = 0;
      step = '{3'd0, 3'd0, DirUp, StatusOutside, 1'b1};
      walk = {walk, step};
      return;
    end
    walk_x = item.start_x;
    walk_y = item.start_y;
    tree_visited[walk_y * MaxW + walk_x] = 1'b1;
    push_cell(walk_x, walk_y);
    tree_count = 1;
    if (total == 1) begin
      step = '{item.start_x, item.start_y, DirUp, StatusSingle, 1'b1};
      walk = {walk, step};
      return;
    end
    while (tree_count < total && walk.size() < ResultLimit) begin
      found = 1'b1;
      nx = walk_x;
      ny = walk_y;
      if (walk_y > 0 && !bool_seen(walk_x, walk_y - 1)) begin
        dir = DirUp;
        ny = walk_y - 1;
      end else if (walk_x > 0 && !bool_seen(walk_x - 1, walk_y)) begin
        dir = DirLeft;
        nx = walk_x - 1;
      end else if (walk_y + 1 < h && !bool_seen(walk_x, walk_y + 1)) begin
        dir = DirDown;
        ny = walk_y + 1;
      end else if (walk_x + 1 < w && !bool_seen(walk_x + 1, walk_y)) begin
        dir = DirRight;
        nx = walk_x + 1;
      end else begin
        found = 1'b0;
      end
      if (found) begin
        walk_x = nx;
        walk_y = ny;
        tree_visited[ny * MaxW + nx] = 1'b1;
        push_cell(nx, ny);
        tree_count++;
        step = '{3'(nx), 3'(ny), dir, StatusEdge, 1'b0};
        walk = {walk, step};
      end else begin
        // dead end: pop and resume at the new top, stop on an empty stack
        if (tree_top > 0) tree_top--;
        if (tree_top == 0) break;
        walk_x = tree_stack[tree_top - 1] % MaxW;
        walk_y = tree_stack[tree_top - 1] / MaxW;
      end
    end
    if (walk.size() > 0) walk[walk.size() - 1].last = 1'b1;
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [CfgW-1:0] pick_dim();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CfgW'($urandom_range(MaxW + 1, 15));
      2: return CfgW'(MaxW);
      3: return CfgW'(1);
      default: return CfgW'($urandom_range(2, MaxW));
    endcase
  endfunction

  task automatic send_start(input in_item_t item, input bit typed, input out_item_t result);
    int        gap;
    out_item_t walk[$];
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall_o !== 1'b0) @(posedge clk);
    if (typed) begin
      tree_edges_due = {tree_edges_due, result};
    end else begin
      walk_tree(item, walk);
      foreach (walk[j]) tree_edges_due = {tree_edges_due, walk[j]};
    end
  endtask

  // hold off new starts until the walk in flight has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tree_edges_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgW-1:0] value);
    for (int pass = 0; pass < 2; pass++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= (pass == 0);
      paddr   <= {idx, 2'b00};
      pwdata  <= ApbDataW'(value);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (pready !== 1'b1) @(posedge clk);
      if (pass == 1 && prdata[CfgW-1:0] !== value) begin
        $display("%0t: register %0d read back expected %0d actual %0d",
                 $time, idx, value, prdata[CfgW-1:0]);
        mismatches++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegGridWidth) cfg_width = value;
    else cfg_height = value;
  endtask

  task automatic apply_grid(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    if (w != cfg_width || h != cfg_height) begin
      wait_idle();
      if (w != cfg_width) write_reg(RegGridWidth, w);
      if (h != cfg_height) write_reg(RegGridHeight, h);
    end
  endtask

  function automatic void check_field(input string field, input logic [2:0] want,
                                      input logic [2:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : edge_check
    out_item_t want;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (tree_edges_due.size() == 0) begin
        $display("%0t: beat with nothing expected, actual %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = tree_edges_due.pop_front();
        check_field("cell_x", want.cell_x, out_data_o.cell_x);
        check_field("cell_y", want.cell_y, out_data_o.cell_y);
        check_field("move_dir", 3'(want.move_dir), 3'(out_data_o.move_dir));
        check_field("status", 3'(want.status), 3'(out_data_o.status));
        check_field("last", 3'(want.last), 3'(out_data_o.last));
      end
    end
  end

  initial begin : edge_sink
    int n;
    wait (rst_n === 1'b1);
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid_o !== 1'b1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int       we;
    int       he;
    in_item_t item;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[i]) begin
      apply_grid(probe_rows[i].grid_w, probe_rows[i].grid_h);
      send_start(probe_rows[i].start, probe_rows[i].typed, probe_rows[i].result);
    end

    for (int phase = 0; phase < 8; phase++) begin
      // every third phase runs with no idling on either side
      calm = (phase % 3 == 2);
      if (phase == 0) apply_grid(CfgW'(MaxW), CfgW'(MaxH));
      else apply_grid(pick_dim(), pick_dim());
      we = eff_dim(cfg_width, MaxW);
      he = eff_dim(cfg_height, MaxH);
      for (int k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 6) != 0) begin
          item.start_x = 3'($urandom_range(0, we - 1));
          item.start_y = 3'($urandom_range(0, he - 1));
        end else begin
          item = in_item_t'(6'($urandom_range(0, 63)));
        end
        send_start(item, 1'b0, '0);
        if ($urandom_range(0, 15) == 0) wait_idle();
      end
    end

    calm = 1'b0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gdst_pkg.sv
rtl/core/gdst_ram.sv
rtl/core/gdst_step.sv
rtl/core/gdst_ctrl.sv
rtl/core/grid_dfs_spanning_tree.sv
bench/grid_dfs_spanning_tree_tb.sv
